@@ rtl/core/dllm_pkg.sv @@
// shared types, constants and codes for the doubly linked list manager
package dllm_pkg;

	localparam int IDX_W          = 8;
	localparam int CMD_W          = 2;
	localparam int IDX_DEPTH      = 2 ** IDX_W;
	localparam int NODE_COUNT_DEF = 256;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CMD_W-1:0] cmd_t;

	localparam cmd_t CMD_INS_AFTER  = 2'd0;
	localparam cmd_t CMD_INS_BEFORE = 2'd1;
	localparam cmd_t CMD_DETACH     = 2'd2;

	localparam idx_t IDX_NONE = 8'd0;
	localparam idx_t LEN_MAX  = 8'hFF;

	typedef struct packed {
		cmd_t command;
		idx_t anchor;
		idx_t node;
	} in_item_t;

	typedef struct packed {
		idx_t affected_node;
		idx_t head_node;
		idx_t tail_node;
		idx_t list_length;
	} out_item_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic start;
		logic commit;
	} dllm_ctl_t;

endpackage

@@ rtl/core/dllm_if.sv @@
// valid/ready channel interfaces for commands and results
interface dllm_in_if;
	import dllm_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface dllm_out_if;
	import dllm_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/dllm_ctrl.sv @@
// controller state machine: command transfer, commit and result register valid
module dllm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output dllm_pkg::dllm_ctl_t ctl
);
	import dllm_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		ctl.start  = 1'b0;
		ctl.commit = 1'b0;
		req_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.start = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!out_valid_q || rsp_ready) begin
					ctl.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

endmodule

@@ rtl/core/dllm_datapath.sv @@
// link memories, head/tail/length registers and result register
module dllm_datapath #(
	parameter int NODE_COUNT = dllm_pkg::NODE_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dllm_pkg::dllm_ctl_t ctl,
	input  dllm_pkg::in_item_t  item,
	output dllm_pkg::out_item_t result
);
	import dllm_pkg::*;

	localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

	typedef logic [AW-1:0] addr_t;

	idx_t next_mem [NODE_COUNT];
	idx_t prev_mem [NODE_COUNT];

	addr_t slot_tbl [IDX_DEPTH];

	cmd_t      cmd_q;
	idx_t      anchor_q;
	idx_t      node_q;
	addr_t     sa_q;
	addr_t     sn_q;
	idx_t      next_rd_q;
	idx_t      prev_rd_q;
	idx_t      head_q;
	idx_t      tail_q;
	idx_t      len_q;
	out_item_t result_q;

	addr_t sa_i;
	addr_t sn_i;
	addr_t ra_i;
	logic  act_i;

	logic  nx_we1, pv_we1;
	addr_t nx_wa1, pv_wa1;
	idx_t  nx_wd1, pv_wd1;

	logic  nx_we2, pv_we2;
	addr_t nx_wa2, pv_wa2;
	idx_t  nx_wd2, pv_wd2;

	logic  act_q;
	logic  a_zero;
	logic  alias_q;
	idx_t  fwd_t;
	idx_t  bwd_t;
	idx_t  fwd_link;
	idx_t  bwd_link;
	addr_t fwd_slot;
	addr_t bwd_slot;
	addr_t rdn_slot;
	addr_t rdp_slot;
	idx_t  head_d;
	idx_t  tail_d;
	idx_t  len_d;

	logic  nx_we, pv_we;
	addr_t nx_wa, pv_wa;
	idx_t  nx_wd, pv_wd;

	// index to memory slot, modulo pool size
	for (genvar g = 0; g < IDX_DEPTH; g++) begin : g_slot
		assign slot_tbl[g] = addr_t'(g % NODE_COUNT);
	end

	assign sa_i  = slot_tbl[item.anchor];
	assign sn_i  = slot_tbl[item.node];
	assign ra_i  = (item.command == CMD_DETACH) ? sn_i : sa_i;
	assign act_i = (item.node != IDX_NONE);

	// first phase: anchor link read plus writes that need no read data
	always_comb begin
		nx_we1 = 1'b0;
		nx_wa1 = sn_i;
		nx_wd1 = item.anchor;
		pv_we1 = 1'b0;
		pv_wa1 = sn_i;
		pv_wd1 = item.anchor;
		if (act_i) begin
			case (item.command)
				CMD_INS_AFTER: begin
					pv_we1 = 1'b1;
					nx_we1 = 1'b1;
					if (item.anchor == IDX_NONE) begin
						nx_wd1 = head_q;
					end else begin
						nx_wa1 = sa_i;
						nx_wd1 = item.node;
					end
				end
				CMD_INS_BEFORE: begin
					nx_we1 = 1'b1;
					pv_we1 = 1'b1;
					if (item.anchor == IDX_NONE) begin
						pv_wd1 = tail_q;
					end else begin
						pv_wa1 = sa_i;
						pv_wd1 = item.node;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign act_q    = (node_q != IDX_NONE);
	assign a_zero   = (anchor_q == IDX_NONE);
	assign alias_q  = !a_zero && (sa_q == sn_q);
	assign fwd_t    = a_zero ? head_q : next_rd_q;
	assign bwd_t    = a_zero ? tail_q : prev_rd_q;
	assign fwd_link = alias_q ? node_q : fwd_t;
	assign bwd_link = alias_q ? node_q : bwd_t;
	assign fwd_slot = slot_tbl[fwd_link];
	assign bwd_slot = slot_tbl[bwd_link];
	assign rdn_slot = slot_tbl[next_rd_q];
	assign rdp_slot = slot_tbl[prev_rd_q];

	// second phase: neighbor links, head, tail and length
	always_comb begin
		nx_we2 = 1'b0;
		nx_wa2 = sn_q;
		nx_wd2 = node_q;
		pv_we2 = 1'b0;
		pv_wa2 = sn_q;
		pv_wd2 = node_q;
		head_d = head_q;
		tail_d = tail_q;
		len_d  = len_q;
		if (act_q) begin
			case (cmd_q)
				CMD_INS_AFTER: begin
					nx_we2 = !a_zero && !alias_q;
					nx_wd2 = fwd_t;
					pv_we2 = (fwd_link != IDX_NONE);
					pv_wa2 = fwd_slot;
					if (a_zero) begin
						head_d = node_q;
					end
					if (fwd_link == IDX_NONE) begin
						tail_d = node_q;
					end
					len_d = (len_q == LEN_MAX) ? len_q : len_q + 8'd1;
				end
				CMD_INS_BEFORE: begin
					pv_we2 = !a_zero && !alias_q;
					pv_wd2 = bwd_t;
					nx_we2 = (bwd_link != IDX_NONE);
					nx_wa2 = bwd_slot;
					if (a_zero) begin
						tail_d = node_q;
					end
					if (bwd_link == IDX_NONE) begin
						head_d = node_q;
					end
					len_d = (len_q == LEN_MAX) ? len_q : len_q + 8'd1;
				end
				CMD_DETACH: begin
					nx_we2 = (prev_rd_q != IDX_NONE);
					nx_wa2 = rdp_slot;
					nx_wd2 = next_rd_q;
					pv_we2 = (next_rd_q != IDX_NONE);
					pv_wa2 = rdn_slot;
					pv_wd2 = prev_rd_q;
					if (prev_rd_q == IDX_NONE) begin
						head_d = next_rd_q;
					end
					if (next_rd_q == IDX_NONE) begin
						tail_d = prev_rd_q;
					end
					len_d = (len_q == IDX_NONE) ? len_q : len_q - 8'd1;
				end
				default: begin
				end
			endcase
		end
	end

	assign nx_we = (ctl.start && nx_we1) || (ctl.commit && nx_we2);
	assign pv_we = (ctl.start && pv_we1) || (ctl.commit && pv_we2);
	assign nx_wa = ctl.start ? nx_wa1 : nx_wa2;
	assign pv_wa = ctl.start ? pv_wa1 : pv_wa2;
	assign nx_wd = ctl.start ? nx_wd1 : nx_wd2;
	assign pv_wd = ctl.start ? pv_wd1 : pv_wd2;

	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_wa] <= nx_wd;
		end
		if (ctl.start) begin
			next_rd_q <= next_mem[ra_i];
		end
	end

	always_ff @(posedge clk) begin
		if (pv_we) begin
			prev_mem[pv_wa] <= pv_wd;
		end
		if (ctl.start) begin
			prev_rd_q <= prev_mem[ra_i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			cmd_q    <= item.command;
			anchor_q <= item.anchor;
			node_q   <= item.node;
			sa_q     <= sa_i;
			sn_q     <= sn_i;
		end
		if (ctl.commit) begin
			result_q.affected_node <= node_q;
			result_q.head_node     <= head_d;
			result_q.tail_node     <= tail_d;
			result_q.list_length   <= len_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= IDX_NONE;
			tail_q <= IDX_NONE;
			len_q  <= IDX_NONE;
		end else if (ctl.commit) begin
			head_q <= head_d;
			tail_q <= tail_d;
			len_q  <= len_d;
		end
	end

	assign result = result_q;

endmodule

@@ rtl/core/doubly_linked_list_manager_unit.sv @@
// top level of the doubly linked list manager
// a command transfer loads the command registers and anchor link reads; ST_EXEC then loads
// the result register once the result slot is free; no new command is taken before that commit,
// since the anchor link read precedes the neighbor link writes on the single-write link memories
// reset: head, tail and length clear at once; link memories are not cleared
// the next command is taken while a finished result waits in the output register
module doubly_linked_list_manager_unit #(
	parameter int NODE_COUNT = dllm_pkg::NODE_COUNT_DEF
) (
	input logic       clk,
	input logic       arst_n,
	dllm_in_if.sink   req,
	dllm_out_if.source rsp
);
	import dllm_pkg::*;

	dllm_ctl_t ctl;
	logic      req_ready;
	logic      rsp_valid;
	out_item_t result;

	dllm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.ctl       (ctl)
	);

	dllm_datapath #(
		.NODE_COUNT (NODE_COUNT)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.item   (req.payload),
		.result (result)
	);

	assign req.ready   = req_ready;
	assign rsp.valid   = rsp_valid;
	assign rsp.payload = result;

endmodule

@@ rtl/core/dllm_chk.sv @@
// port-level checker for the doubly linked list manager, bound to the top level
module dllm_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input dllm_pkg::idx_t      req_node,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input dllm_pkg::out_item_t rsp_payload
);
	import dllm_pkg::*;

	// one command in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("command taken while another is in flight");

	// a new result only follows a cycle in which no command could be taken
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !$past(rsp_valid) |-> !$past(req_ready))
		else $error("result appeared without a command in progress");

	// with a free result slot, the result follows the command and carries its node, unless that node is IDX_NONE
	a_result_node: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) ##1 (!rsp_valid || rsp_ready) |=>
		rsp_valid && (rsp_payload.affected_node == $past(req_node, 2) ||
		$past(req_node, 2) == IDX_NONE))
		else $error("result missing or wrong affected node");

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("stalled result changed");

endmodule

bind doubly_linked_list_manager_unit dllm_chk u_dllm_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_node    (req.payload.node),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);
